// File: rtl/pfc_pkg.sv
// pfc_pkg: shared constants, state type and square arithmetic helpers
// for the playfair cipher engine; no dependencies
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int unsigned SIDE           = 5;
  localparam int unsigned SQUARE_LETTERS = SIDE * SIDE;
  localparam int unsigned ALPHA          = 26;
  localparam int unsigned POS_W          = $clog2(SQUARE_LETTERS);
  localparam int unsigned LET_W          = $clog2(ALPHA);
  localparam int unsigned RC_W           = $clog2(SIDE);
  localparam int unsigned MAX_PAIRS      = 3;
  localparam int unsigned PIDX_W         = $clog2(MAX_PAIRS);

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [LET_W-1:0] IDX_J = LET_W'(9);

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;
  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SWEEP = 6'b000010,
    S_LOOK  = 6'b000100,
    S_SQ    = 6'b001000,
    S_EMIT0 = 6'b010000,
    S_EMIT1 = 6'b100000
  } pfc_state_t;

  // row of a square position, by range compare
  function automatic logic [RC_W-1:0] row_of(input logic [POS_W-1:0] pos);
    logic [RC_W-1:0] r;
    r = '0;
    for (int k = 1; k < SIDE; k++) begin
      if (pos >= POS_W'(k * SIDE)) r = RC_W'(k);
    end
    return r;
  endfunction

  // column of a square position given its row
  function automatic logic [RC_W-1:0] col_of(input logic [POS_W-1:0] pos,
                                            input logic [RC_W-1:0] row);
    logic [POS_W-1:0] base;
    base = POS_W'(row) * POS_W'(SIDE);
    return RC_W'(pos - base);
  endfunction

  // cyclic step along a row or column
  function automatic logic [RC_W-1:0] shift_rc(input logic [RC_W-1:0] p,
                                              input logic dir);
    logic [RC_W-1:0] q;
    if (dir == DIR_DEC) q = (p == '0) ? RC_W'(SIDE - 1) : p - RC_W'(1);
    else                q = (p == RC_W'(SIDE - 1)) ? '0 : p + RC_W'(1);
    return q;
  endfunction

  function automatic logic [POS_W-1:0] pos_of(input logic [RC_W-1:0] r,
                                             input logic [RC_W-1:0] c);
    return POS_W'(r) * POS_W'(SIDE) + POS_W'(c);
  endfunction

endpackage

// File: rtl/playfair_cipher_engine_top.sv
// playfair_cipher_engine_top: playfair engine with key square and letter
// position tables in synchronous memories; depends on pfc_pkg
// a message item runs per digraph through a position read (S_LOOK), a square
//   read (S_SQ) and two emits (S_EMIT0, S_EMIT1) that wait for a free output
//   register, up to 3 digraphs per item; no new item is taken until it is done;
//   a last key item is followed by the alphabet fill sweep over the letter counter
// reset: synchronous active-low rst_n clears control state, square contents
//   stay undefined until a key is written
`timescale 1ns / 1ps

module playfair_cipher_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_char,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_out
);
  import pfc_pkg::*;

  // memories: one write port, two registered read ports each
  logic [LET_W-1:0] key_square  [SQUARE_LETTERS];
  logic [POS_W-1:0] letter_place[ALPHA];

  pfc_state_t       state_r, state_nxt;
  logic             dir_r;
  logic [ALPHA-1:0] used_r, used_nxt;
  logic [POS_W-1:0] fill_r, fill_nxt;
  logic             key_open_r, key_open_nxt;
  logic             held_v_r, held_v_nxt;
  logic [7:0]       held_c_r, held_c_nxt;
  logic             odd_r, odd_nxt;
  logic [LET_W-1:0] sweep_r, sweep_nxt;

  logic [7:0]        pa_r [MAX_PAIRS];
  logic [7:0]        pb_r [MAX_PAIRS];
  logic [7:0]        pa_nxt [MAX_PAIRS];
  logic [7:0]        pb_nxt [MAX_PAIRS];
  logic [PIDX_W:0]   pcnt_r, pcnt_nxt;
  logic [PIDX_W-1:0] pidx_r, pidx_nxt;
  logic              item_last_r, item_last_nxt;

  logic             va_r, vb_r;
  logic [POS_W-1:0] lp_d0, lp_d1;
  logic [LET_W-1:0] ks_d0, ks_d1;

  logic             ov_r, ov_nxt;
  logic [7:0]       oc_r, oc_nxt;
  logic             ol_r, ol_nxt;

  logic in_xfer, out_free;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;

  // letter placement shared by key items and the fill sweep
  logic             pl_try, pl_en;
  logic [LET_W-1:0] pl_idx;
  logic [ALPHA-1:0] used_base;
  logic [POS_W-1:0] fill_base;
  logic             key_letter;

  always_comb begin
    used_base  = (in_xfer && key_open_r) ? '0 : used_r;
    fill_base  = (in_xfer && key_open_r) ? '0 : fill_r;
    key_letter = (in_char >= CH_A) && (in_char <= CH_Z);
    if (state_r == S_SWEEP) begin
      pl_try = 1'b1;
      pl_idx = sweep_r;
    end else begin
      pl_try = in_xfer && (in_mode == MODE_KEY) && key_letter;
      pl_idx = LET_W'(in_char - CH_A);
    end
    pl_en = pl_try && (pl_idx != IDX_J) && !used_base[pl_idx] &&
            (fill_base < POS_W'(SQUARE_LETTERS));
  end

  always_ff @(posedge clk) begin
    if (pl_en) begin
      key_square[fill_base] <= pl_idx;
      letter_place[pl_idx]  <= fill_base;
    end
  end

  // pair lookup addresses
  logic             la_ok, lb_ok;
  logic [LET_W-1:0] la_idx, lb_idx;
  always_comb begin
    la_idx = LET_W'(pa_r[pidx_r] - CH_A);
    lb_idx = LET_W'(pb_r[pidx_r] - CH_A);
    la_ok  = (pa_r[pidx_r] >= CH_A) && (pa_r[pidx_r] <= CH_Z) &&
             (la_idx != IDX_J) && used_r[la_idx];
    lb_ok  = (pb_r[pidx_r] >= CH_A) && (pb_r[pidx_r] <= CH_Z) &&
             (lb_idx != IDX_J) && used_r[lb_idx];
  end

  // letter position read, only when looking up a pair
  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      lp_d0 <= letter_place[la_ok ? la_idx : '0];
      lp_d1 <= letter_place[lb_ok ? lb_idx : '0];
      va_r  <= la_ok;
      vb_r  <= lb_ok;
    end
  end

  // digraph rule on positions
  logic [POS_W-1:0] pos_a, pos_b, q0, q1;
  logic [RC_W-1:0]  r1, c1, r2, c2;
  always_comb begin
    pos_a = (va_r && lp_d0 < POS_W'(SQUARE_LETTERS)) ? lp_d0 : '0;
    pos_b = (vb_r && lp_d1 < POS_W'(SQUARE_LETTERS)) ? lp_d1 : '0;
    r1 = row_of(pos_a);
    c1 = col_of(pos_a, r1);
    r2 = row_of(pos_b);
    c2 = col_of(pos_b, r2);
    if (r1 == r2) begin
      q0 = pos_of(r1, shift_rc(c1, dir_r));
      q1 = pos_of(r2, shift_rc(c2, dir_r));
    end else if (c1 == c2) begin
      q0 = pos_of(shift_rc(r1, dir_r), c1);
      q1 = pos_of(shift_rc(r2, dir_r), c2);
    end else begin
      q0 = pos_of(r1, c2);
      q1 = pos_of(r2, c1);
    end
  end

  // square read, held until the next pair
  always_ff @(posedge clk) begin
    if (state_r == S_SQ) begin
      ks_d0 <= key_square[q0];
      ks_d1 <= key_square[q1];
    end
  end

  // pair formation on a message transfer
  always_comb begin
    logic       hv, od;
    logic [7:0] hc;
    logic [PIDX_W:0] n;
    hv = held_v_r;
    hc = held_c_r;
    od = odd_r;
    n  = '0;
    for (int k = 0; k < MAX_PAIRS; k++) begin
      pa_nxt[k] = pa_r[k];
      pb_nxt[k] = pb_r[k];
    end
    if (in_char != CH_SPACE) begin
      od = !od;
      if (!hv) begin
        hc = in_char;
        hv = 1'b1;
      end else if (hc == in_char) begin
        pa_nxt[n[PIDX_W-1:0]] = hc;
        pb_nxt[n[PIDX_W-1:0]] = CH_X;
        n = n + 1'b1;
      end else begin
        pa_nxt[n[PIDX_W-1:0]] = hc;
        pb_nxt[n[PIDX_W-1:0]] = in_char;
        n  = n + 1'b1;
        hv = 1'b0;
      end
    end
    if (in_last_in) begin
      if (od) begin
        if (!hv) begin
          hc = CH_X;
          hv = 1'b1;
        end else if (hc == CH_X) begin
          pa_nxt[n[PIDX_W-1:0]] = hc;
          pb_nxt[n[PIDX_W-1:0]] = CH_X;
          n = n + 1'b1;
        end else begin
          pa_nxt[n[PIDX_W-1:0]] = hc;
          pb_nxt[n[PIDX_W-1:0]] = CH_X;
          n  = n + 1'b1;
          hv = 1'b0;
        end
      end
      if (hv) begin
        pa_nxt[n[PIDX_W-1:0]] = hc;
        pb_nxt[n[PIDX_W-1:0]] = CH_X;
        n  = n + 1'b1;
        hv = 1'b0;
      end
      hc = '0;
      od = 1'b0;
    end
    pcnt_nxt   = n;
    held_v_nxt = hv;
    held_c_nxt = hc;
    odd_nxt    = od;
  end

  // sequencer
  logic [PIDX_W:0] pidx_inc;
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    key_open_nxt  = key_open_r;
    sweep_nxt     = sweep_r;
    pidx_nxt      = pidx_r;
    item_last_nxt = item_last_r;
    ov_nxt        = ov_r && !out_ready;
    oc_nxt        = oc_r;
    ol_nxt        = ol_r;
    pidx_inc      = {1'b0, pidx_r} + 1'b1;
    if (pl_en) begin
      used_nxt = used_base | (ALPHA'(1) << pl_idx);
      fill_nxt = fill_base + 1'b1;
    end else if (in_xfer && in_mode == MODE_KEY) begin
      used_nxt = used_base;
      fill_nxt = fill_base;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_mode == MODE_KEY) begin
          key_open_nxt = in_last_in;
          if (in_last_in) begin
            sweep_nxt = '0;
            state_nxt = S_SWEEP;
          end
        end else if (in_xfer) begin
          item_last_nxt = in_last_in;
          pidx_nxt      = '0;
          if (pcnt_nxt != '0) state_nxt = S_LOOK;
        end
      end
      S_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LET_W'(ALPHA - 1)) state_nxt = S_IDLE;
      end
      S_LOOK: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_EMIT0;
      S_EMIT0: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = CH_A + 8'(ks_d0);
          ol_nxt    = 1'b0;
          state_nxt = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oc_nxt = CH_A + 8'(ks_d1);
          ol_nxt = item_last_r && (pidx_inc == pcnt_r);
          if (pidx_inc == pcnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            pidx_nxt  = pidx_inc[PIDX_W-1:0];
            state_nxt = S_LOOK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dir_r      <= DIR_ENC;
      used_r     <= '0;
      fill_r     <= '0;
      key_open_r <= 1'b1;
      held_v_r   <= 1'b0;
      held_c_r   <= '0;
      odd_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      key_open_r <= key_open_nxt;
      ov_r       <= ov_nxt;
      if (cfg_wr_en) dir_r <= cfg_wr_data;
      if (in_xfer && in_mode == MODE_MSG) begin
        held_v_r <= held_v_nxt;
        held_c_r <= held_c_nxt;
        odd_r    <= odd_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sweep_r     <= sweep_nxt;
    pidx_r      <= pidx_nxt;
    item_last_r <= item_last_nxt;
    oc_r        <= oc_nxt;
    ol_r        <= ol_nxt;
    if (in_xfer && in_mode == MODE_MSG) begin
      pcnt_r <= pcnt_nxt;
      for (int k = 0; k < MAX_PAIRS; k++) begin
        pa_r[k] <= pa_nxt[k];
        pb_r[k] <= pb_nxt[k];
      end
    end
  end

  assign out_valid    = ov_r;
  assign out_char     = oc_r;
  assign out_last_out = ol_r;

endmodule

// File: rtl/pfc_checker.sv
// pfc_checker: port-level assertions for the playfair cipher engine,
// bound to playfair_cipher_engine_top; no package dependencies
`timescale 1ns / 1ps

module pfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last_out
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result shown right after reset");

  // a key transfer with nothing pending produces no result
  a_key_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_mode && !out_valid) |=> !out_valid)
    else $error("key transfer produced a result");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_char) && $stable(out_last_out)))
    else $error("result payload changed while stalled");

endmodule

bind playfair_cipher_engine_top pfc_checker u_pfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_mode     (in_mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_char    (out_char),
  .out_last_out(out_last_out)
);

// File: tb/playfair_cipher_engine_top_tb.sv
// playfair_cipher_engine_top_tb: self-checking bench for the playfair engine
// drives keys and messages, predicts every output character; needs pfc_pkg
`timescale 1ns / 1ps

module playfair_cipher_engine_top_tb;
  import pfc_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic       in_mode;
  logic [7:0] in_char;
  logic       in_last_in;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_last_out;

  playfair_cipher_engine_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_char(in_char), .in_last_in(in_last_in), .out_valid(out_valid),
    .out_ready(out_ready), .out_char(out_char), .out_last_out(out_last_out)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cipher_out_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic       last;
    logic       has_exp;
    logic [7:0] exp_ch;
    logic       exp_last;
  } stim_row_t;

  // predictor state
  logic [4:0]  sq_letter [SQUARE_LETTERS];
  logic [4:0]  sq_place  [ALPHA];
  logic [25:0] sq_used;
  int          sq_fill;
  logic        sq_open;
  logic        msg_held_v;
  logic [7:0]  msg_held;
  logic        msg_odd;
  logic        mdl_dir;

  cipher_out_t expected_chars[$];
  cipher_out_t step_out[$];
  int          errors;
  int          n_out;
  int          n_in;
  int          idle_cnt;
  bit          hold_long;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_letter(input int idx);
    if (idx >= ALPHA || idx == int'(IDX_J) || sq_used[idx] || sq_fill >= SQUARE_LETTERS)
      return;
    sq_letter[sq_fill] = 5'(idx);
    sq_place[idx] = 5'(sq_fill);
    sq_used[idx] = 1'b1;
    sq_fill++;
  endfunction

  function automatic int find_pos(input logic [7:0] c);
    int idx;
    if (c < CH_A || c > CH_Z) return 0;
    idx = int'(c - CH_A);
    if (idx == int'(IDX_J) || !sq_used[idx]) return 0;
    return (sq_place[idx] >= SQUARE_LETTERS) ? 0 : int'(sq_place[idx]);
  endfunction

  function automatic int step_rc(input int p);
    return (mdl_dir == DIR_DEC) ? (p + SIDE - 1) % SIDE : (p + 1) % SIDE;
  endfunction

  function automatic void push_char(input int r, input int c);
    cipher_out_t o;
    o.ch = CH_A + 8'(sq_letter[(r % SIDE) * SIDE + (c % SIDE)]);
    o.last = 1'b0;
    step_out = {step_out, o};
  endfunction

  function automatic void encode_pair(input logic [7:0] a, input logic [7:0] b);
    int pa, pb, r1, c1, r2, c2;
    pa = find_pos(a);
    pb = find_pos(b);
    r1 = pa / SIDE; c1 = pa % SIDE; r2 = pb / SIDE; c2 = pb % SIDE;
    if (r1 == r2) begin
      push_char(r1, step_rc(c1));
      push_char(r2, step_rc(c2));
    end else if (c1 == c2) begin
      push_char(step_rc(r1), c1);
      push_char(step_rc(r2), c2);
    end else begin
      push_char(r1, c2);
      push_char(r2, c1);
    end
  endfunction

  function automatic void pair_up(input logic [7:0] c);
    if (!msg_held_v) begin
      msg_held = c;
      msg_held_v = 1'b1;
    end else if (msg_held == c) begin
      encode_pair(msg_held, CH_X);
    end else begin
      encode_pair(msg_held, c);
      msg_held_v = 1'b0;
    end
  endfunction

  // one input transfer through the predictor; results land in step_out
  function automatic void cipher_step(input logic mode, input logic [7:0] c,
                                      input logic last);
    step_out.delete();
    if (mode == MODE_KEY) begin
      if (sq_open) begin
        sq_used = '0;
        sq_fill = 0;
        sq_open = 1'b0;
      end
      if (c >= CH_A && c <= CH_Z) add_letter(int'(c - CH_A));
      if (last) begin
        for (int l = 0; l < ALPHA; l++) add_letter(l);
        sq_open = 1'b1;
      end
      return;
    end
    if (c != CH_SPACE) begin
      msg_odd = ~msg_odd;
      pair_up(c);
    end
    if (last) begin
      if (msg_odd) pair_up(CH_X);
      if (msg_held_v) begin
        encode_pair(msg_held, CH_X);
        msg_held_v = 1'b0;
      end
      msg_held = '0;
      msg_odd = 1'b0;
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    cipher_out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected output expected none actual char %h last %b",
                 $time, out_char, out_last_out);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (e.ch !== out_char)
          $display("%0t: out_char mismatch expected %h actual %h", $time, e.ch, out_char);
        if (e.last !== out_last_out)
          $display("%0t: out_last_out mismatch expected %b actual %b",
                   $time, e.last, out_last_out);
        if (e.ch !== out_char || e.last !== out_last_out) errors++;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_long = 1'b0;
      end
      w = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
        @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // valid stays up after the transfer until the next item or an idle gap
  task automatic send_item(input logic mode, input logic [7:0] c, input logic last,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_char <= c;
    in_last_in <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cipher_step(mode, c, last);
    expected_chars = {expected_chars, step_out};
    n_in++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_chars.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_direction(input logic d);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mdl_dir = d;
  endtask

  function automatic logic [7:0] rand_letter();
    return CH_A + 8'($urandom_range(0, 25));
  endfunction

  task automatic send_random_key();
    int len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++)
      send_item(MODE_KEY, ($urandom_range(0, 7) == 0) ? 8'($urandom) : rand_letter(),
                i == len - 1, $urandom_range(0, 5));
  endtask

  task automatic send_random_message(input int len);
    logic [7:0] c;
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) c = CH_SPACE;
      else if (pick == 1) c = 8'($urandom);
      else if (pick == 2 && i > 0) c = in_char;  // repeat letter for doubles
      else c = rand_letter();
      send_item(MODE_MSG, c, i == len - 1, $urandom_range(0, 5));
    end
  endtask

  stim_row_t directed_rows[$];

  function automatic stim_row_t mk(input logic m, input logic [7:0] c, input logic l);
    stim_row_t r;
    r = '{mode: m, ch: c, last: l, has_exp: 1'b0, exp_ch: '0, exp_last: 1'b0};
    return r;
  endfunction

  initial begin
    stim_row_t r;
    cipher_out_t first;
    string key_text;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_char = '0;
    in_last_in = 1'b0;
    errors = 0; n_out = 0; n_in = 0; idle_cnt = 0;
    hold_long = 1'b0;
    sq_used = '0; sq_fill = 0; sq_open = 1'b1;
    msg_held_v = 1'b0; msg_held = '0; msg_odd = 1'b0; mdl_dir = DIR_ENC;
    for (int i = 0; i < SQUARE_LETTERS; i++) sq_letter[i] = '0;
    for (int i = 0; i < ALPHA; i++) sq_place[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    set_direction(DIR_ENC);

    // directed table: key with junk bytes, then edge-case messages
    key_text = "playfAir9j ex";
    for (int i = 0; i < key_text.len(); i++)
      directed_rows = {directed_rows, mk(MODE_KEY, key_text[i], 1'b0)};
    directed_rows = {directed_rows, mk(MODE_KEY, 8'hff, 1'b1)};
    // non-letters, a doubled letter and odd-count padding with x
    directed_rows = {directed_rows, mk(MODE_MSG, 8'h00, 1'b0)};
    directed_rows = {directed_rows, mk(MODE_MSG, CH_SPACE, 1'b0)};
    directed_rows = {directed_rows, mk(MODE_MSG, "e", 1'b0)};
    directed_rows = {directed_rows, mk(MODE_MSG, "e", 1'b0)};
    directed_rows = {directed_rows, mk(MODE_MSG, "J", 1'b0)};
    directed_rows = {directed_rows, mk(MODE_MSG, "x", 1'b1)};
    directed_rows = {directed_rows, mk(MODE_MSG, CH_SPACE, 1'b1)};  // empty message
    directed_rows = {directed_rows, mk(MODE_MSG, "z", 1'b1)};
    // "pl" sits in one row: p,l -> l,a on encipher
    r = mk(MODE_MSG, "p", 1'b0);
    directed_rows = {directed_rows, r};
    r = mk(MODE_MSG, "l", 1'b1);
    r.has_exp = 1'b1; r.exp_ch = "l"; r.exp_last = 1'b0;
    directed_rows = {directed_rows, r};

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_item(r.mode, r.ch, r.last, $urandom_range(0, 5));
      if (r.has_exp) begin
        first = (step_out.size() > 0) ? step_out[0] : '0;
        if (step_out.size() == 0 || first.ch !== r.exp_ch || first.last !== r.exp_last) begin
          $display("%0t: table mismatch expected %h/%b actual %h/%b", $time,
                   r.exp_ch, r.exp_last, first.ch, first.last);
          errors++;
        end
      end
    end

    set_direction(DIR_DEC);
    send_random_message(7);
    set_direction(DIR_ENC);

    // long receiver hold-off while the sender keeps offering
    hold_long = 1'b1;
    send_random_message(40);
    drain();

    // random phases: new keys, messages, direction flips
    while (n_in < 520) begin
      if ($urandom_range(0, 3) == 0) send_random_key();
      if ($urandom_range(0, 4) == 0) set_direction(1'($urandom_range(0, 1)));
      send_random_message($urandom_range(1, 14));
      if ($urandom_range(0, 7) == 0) drain();  // sender waits for all results
    end
    set_direction(DIR_DEC);
    send_random_message(10);
    drain();

    $display("covered %0d input transfers and %0d output characters", n_in, n_out);
    $display("both directions, key rebuilds, doubled letters, padding and stalls");
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pfc_pkg.sv
rtl/playfair_cipher_engine_top.sv
rtl/pfc_checker.sv
tb/playfair_cipher_engine_top_tb.sv
